// ----- rtl/bmxt_pkg.sv -----
// shared types, codes and sizing helpers for the bounded max-xor trie
package bmxt_pkg;

  localparam int DEF_KEY_BITS  = 31;
  localparam int DEF_NODE_POOL = 32768;

  localparam int KEY_MAX = 32;
  localparam int IDX_MAX = 20;
  localparam int FIELD_W = 31;
  localparam int NEED_W  = 6;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [1:0] OP_PROBE  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic                vld;
    logic [1:0]          op;
    logic                fresh;
    logic                halt;
    logic                none;
    logic [KEY_MAX-1:0]  key;
    logic [FIELD_W-1:0]  limit;
    logic [IDX_MAX-1:0]  idx;
    logic [KEY_MAX-1:0]  acc;
    logic [NEED_W-1:0]   need;
  } tok_t;

  // most nodes that can sit at one trie depth
  function automatic int level_nodes(int level, int pool);
    if (level >= IDX_MAX + 1) begin
      return pool;
    end
    return ((1 << level) < pool) ? (1 << level) : pool;
  endfunction

  function automatic int idx_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- rtl/bmxt_if.sv -----
// request and response channel interfaces
interface bmxt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [30:0] key;
  logic [30:0] limit;

  modport source (output valid, output func, output key, output limit, input ready);
  modport sink (input valid, input func, input key, input limit, output ready);
endinterface

interface bmxt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [30:0] answer;

  modport source (output valid, output status, output answer, input ready);
  modport sink (input valid, input status, input answer, output ready);
endinterface

// ----- rtl/bmxt_cell.sv -----
// one trie depth: node memory for that depth, child allocation, walk step
module bmxt_cell #(
  parameter int LEVEL     = 0,
  parameter int KEY_BITS  = bmxt_pkg::DEF_KEY_BITS,
  parameter int NODE_POOL = bmxt_pkg::DEF_NODE_POOL
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  bmxt_pkg::tok_t tok_in,
  output bmxt_pkg::tok_t tok_out
);

  localparam int ND   = bmxt_pkg::level_nodes(LEVEL, NODE_POOL);
  localparam int IW   = bmxt_pkg::idx_bits(ND);
  localparam int CND  = bmxt_pkg::level_nodes(LEVEL + 1, NODE_POOL);
  localparam int CIW  = bmxt_pkg::idx_bits(CND);
  localparam int CW   = $clog2(CND + 1);
  localparam int BIT  = KEY_BITS - 1 - LEVEL;
  localparam int SW   = 1 + CIW + KEY_BITS;
  localparam int EW   = 2 * SW;
  localparam int IXW  = bmxt_pkg::IDX_MAX;
  localparam int NW   = bmxt_pkg::NEED_W;

  logic [EW-1:0]       mem [ND];
  logic [EW-1:0]       rdata;
  logic [EW-1:0]       ent;
  logic [EW-1:0]       ent_next;
  bmxt_pkg::tok_t      tok_a;
  bmxt_pkg::tok_t      tok_next;
  logic [CW-1:0]       cnt;
  logic                wr;
  logic                alloc;
  logic                b;
  logic                v [2];
  logic [CIW-1:0]      ci [2];
  logic [KEY_BITS-1:0] m [2];
  logic [31:0]         m32 [2];
  logic [31:0]         lim32;
  logic [KEY_BITS-1:0] k;

  always_ff @(posedge clk) begin
    if (tok_in.vld) begin
      rdata <= mem[tok_in.idx[IW-1:0]];
    end
    if (wr) begin
      mem[tok_a.idx[IW-1:0]] <= ent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a   <= '0;
      tok_out <= '0;
    end else begin
      tok_a   <= tok_in;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (alloc) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_comb begin
    ent   = tok_a.fresh ? '0 : rdata;
    b     = tok_a.key[BIT];
    k     = tok_a.key[KEY_BITS-1:0];
    lim32 = {1'b0, tok_a.limit};
    for (int s = 0; s < 2; s++) begin
      v[s]   = ent[s*SW + SW - 1];
      ci[s]  = ent[s*SW + KEY_BITS +: CIW];
      m[s]   = ent[s*SW +: KEY_BITS];
      m32[s] = 32'(m[s]);
    end

    tok_next = tok_a;
    ent_next = ent;
    wr       = 1'b0;
    alloc    = 1'b0;

    case (tok_a.op)
      bmxt_pkg::OP_QUERY: begin
        if (!tok_a.halt) begin
          if (v[~b] && (m32[~b] <= lim32)) begin
            tok_next.acc[BIT] = 1'b1;
            tok_next.idx      = IXW'(ci[~b]);
          end else if (v[b] && (m32[b] <= lim32)) begin
            tok_next.idx = IXW'(ci[b]);
          end else begin
            tok_next.halt = 1'b1;
            tok_next.none = (LEVEL == 0);
          end
        end
      end
      bmxt_pkg::OP_PROBE: begin
        if (tok_a.fresh || !v[b]) begin
          tok_next.fresh = 1'b1;
          tok_next.need  = tok_a.need + NW'(1);
        end else begin
          tok_next.idx = IXW'(ci[b]);
        end
      end
      bmxt_pkg::OP_INSERT: begin
        wr = tok_a.vld;
        if (v[b]) begin
          if (k < m[b]) begin
            ent_next[32'(b)*SW +: SW] = {1'b1, ci[b], k};
          end
          tok_next.idx   = IXW'(ci[b]);
          tok_next.fresh = 1'b0;
        end else begin
          alloc                     = tok_a.vld;
          ent_next[32'(b)*SW +: SW] = {1'b1, cnt[CIW-1:0], k};
          tok_next.idx              = IXW'(cnt[CIW-1:0]);
          tok_next.fresh            = 1'b1;
          tok_next.need             = tok_a.need + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/bounded_max_xor_trie.sv -----
// top level: request control, chain of per-depth trie cells, response register
// clear and unused codes go from request control straight to the response register; query and insert
// move down the chain of cells, with a read step and an update step at each trie depth
// insert when the node pool may run short: one probe pass first, then the insert pass if the pool has room
// one item in flight at a time; a finished response waits in its register
// reset empties the trie at once, with no clearing pass; node memories are not reset
module bounded_max_xor_trie #(
  parameter int KEY_BITS  = bmxt_pkg::DEF_KEY_BITS,
  parameter int NODE_POOL = bmxt_pkg::DEF_NODE_POOL
) (
  input  logic       clk,
  input  logic       rst,
  bmxt_req_if.sink   req,
  bmxt_rsp_if.source rsp
);

  localparam int NUW = $clog2(NODE_POOL + 1);
  localparam int UW  = NUW + 1;
  localparam int KM  = bmxt_pkg::KEY_MAX;
  localparam int FW  = bmxt_pkg::FIELD_W;
  localparam logic [KM-1:0] KEY_MASK = KM'((64'd1 << KEY_BITS) - 64'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  bmxt_pkg::tok_t    chain [KEY_BITS+1];
  bmxt_pkg::tok_t    launch;
  bmxt_pkg::tok_t    tail;
  logic [1:0]        state;
  logic [NUW-1:0]    nodes_used;
  logic              root_new;
  logic              clear;
  logic [KM-1:0]     cur_key;
  logic [KM-1:0]     key_in;
  logic [1:0]        res_status;
  logic [FW-1:0]     res_answer;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [FW-1:0]     out_answer;
  logic              out_free;
  logic              may_fill;
  logic              over;

  function automatic bmxt_pkg::tok_t make_tok(logic [1:0] op, logic [KM-1:0] k,
                                              logic [FW-1:0] lim, logic fresh);
    bmxt_pkg::tok_t t;
    t       = '0;
    t.vld   = 1'b1;
    t.op    = op;
    t.key   = k;
    t.limit = lim;
    t.fresh = fresh;
    return t;
  endfunction

  assign chain[0]   = launch;
  assign tail       = chain[KEY_BITS];
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.answer = out_answer;
  assign out_free   = !out_valid || rsp.ready;
  assign key_in     = {1'b0, req.key} & KEY_MASK;
  assign may_fill   = ({1'b0, nodes_used} + UW'(KEY_BITS)) > UW'(NODE_POOL);
  assign over       = ({1'b0, nodes_used} + UW'(tail.need)) > UW'(NODE_POOL);

  for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
    bmxt_cell #(
      .LEVEL     (g),
      .KEY_BITS  (KEY_BITS),
      .NODE_POOL (NODE_POOL)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= '0;
      nodes_used <= NUW'(1);
      root_new   <= 1'b1;
      clear      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      clear     <= (state == S_IDLE) && req.valid && (req.func == bmxt_pkg::FN_CLEAR);
      out_valid <= (state == S_FIN) || (out_valid && !rsp.ready);
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_key <= key_in;
            case (req.func)
              bmxt_pkg::FN_CLEAR: begin
                nodes_used <= NUW'(1);
                root_new   <= 1'b1;
                res_status <= bmxt_pkg::ST_DONE;
                res_answer <= '0;
                state      <= S_FIN;
              end
              bmxt_pkg::FN_INSERT: begin
                launch <= make_tok(may_fill ? bmxt_pkg::OP_PROBE : bmxt_pkg::OP_INSERT,
                                   key_in, req.limit, root_new);
                state  <= S_RUN;
              end
              bmxt_pkg::FN_QUERY: begin
                launch <= make_tok(bmxt_pkg::OP_QUERY, key_in, req.limit, root_new);
                state  <= S_RUN;
              end
              default: begin
                res_status <= bmxt_pkg::ST_DONE;
                res_answer <= '0;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_RUN: begin
          if (tail.vld && (tail.op == bmxt_pkg::OP_PROBE) && !over) begin
            launch <= make_tok(bmxt_pkg::OP_INSERT, cur_key, '0, root_new);
          end else begin
            launch.vld <= 1'b0;
          end
          if (tail.vld) begin
            case (tail.op)
              bmxt_pkg::OP_PROBE: begin
                if (over) begin
                  res_status <= bmxt_pkg::ST_FULL;
                  res_answer <= '0;
                  state      <= S_FIN;
                end
              end
              bmxt_pkg::OP_INSERT: begin
                nodes_used <= NUW'(nodes_used + NUW'(tail.need));
                root_new   <= 1'b0;
                res_status <= bmxt_pkg::ST_DONE;
                res_answer <= '0;
                state      <= S_FIN;
              end
              bmxt_pkg::OP_QUERY: begin
                if (tail.none) begin
                  res_status <= bmxt_pkg::ST_NONE;
                  res_answer <= '0;
                end else begin
                  res_status <= bmxt_pkg::ST_FOUND;
                  res_answer <= tail.acc[FW-1:0];
                end
                state <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_status <= res_status;
            out_answer <= res_answer;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bmxt_checker.sv -----
// port-level checks for the bounded max-xor trie, bound to the top level
module bmxt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [30:0] rsp_answer
);

  logic [1:0] pend;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pend <= pend + 2'd1;
    end else if (!req_xfer && rsp_xfer) begin
      pend <= pend - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_answer))
    else $error("response changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("request taken while an item is in flight");

  a_answer_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != bmxt_pkg::ST_FOUND) |-> rsp_answer == '0)
    else $error("nonzero answer without a found status");

  a_pending: assert property (@(posedge clk) disable iff (rst)
    (pend != 2'd3) && (!rsp_valid || (pend != 2'd0)))
    else $error("response count does not match request transfers");

endmodule

bind bounded_max_xor_trie bmxt_checker u_bmxt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_answer (rsp.answer)
);
